/* hdl/brl_pkg.sv */
// Shared constants for the line rasterizer.
package brl_pkg;

	// default coordinate width and fixed colour width
	localparam int COORD_BITS_DEF = 12;
	localparam int COLOR_BITS     = 16;

	// command queue depth between front end and stepper
	localparam int QUEUE_DEPTH_DEF = 4;

	// request codes
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

endpackage

/* hdl/brl_front.sv */
// Front end: accepts requests, classifies steepness and packs queue entries.
module brl_front
	import brl_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ENTRY_W    = 2 + 4 * COORD_BITS + COLOR_BITS
) (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0]        color_value,
	input  logic                         queue_full,
	output logic                         push,
	output logic [ENTRY_W-1:0]           push_data
);

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS:0]        adx, ady;
	logic                       steep;
	logic [COORD_BITS-1:0]      a_maj, a_min, b_maj, b_min;

	always_comb begin
		dx    = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
		dy    = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
		adx   = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
		ady   = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
		// equal deltas keep x as the major axis
		steep = ady > adx;
		if (steep) begin
			a_maj = y_start;
			a_min = x_start;
			b_maj = y_end;
			b_min = x_end;
		end else begin
			a_maj = x_start;
			a_min = y_start;
			b_maj = x_end;
			b_min = y_end;
		end
	end

	assign in_ready  = !queue_full;
	assign push      = in_valid && in_ready;
	assign push_data = {req_type, steep, a_maj, a_min, b_maj, b_min, color_value};

endmodule

/* hdl/brl_fifo.sv */
// Command queue between front end and stepper.
module brl_fifo
	import brl_pkg::*;
#(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

endmodule

/* hdl/brl_back.sv */
// Stepper: loads lines, walks the error term and drives the pixel register.
module brl_back
	import brl_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ENTRY_W    = 2 + 4 * COORD_BITS + COLOR_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  logic [ENTRY_W-1:0]           head_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0]        pixel_color,
	output logic                         last_pixel
);

	localparam int EW = COORD_BITS + 2;

	// unpacked queue head
	logic                         hd_req, hd_steep;
	logic signed [COORD_BITS-1:0] hd_a_maj, hd_a_min, hd_b_maj, hd_b_min;
	logic [COLOR_BITS-1:0]        hd_color;

	// line state
	logic                         line_active_q, axes_swapped_q, minor_down_q;
	logic signed [COORD_BITS-1:0] major_pos_q, minor_pos_q, major_end_q;
	logic [COORD_BITS-1:0]        delta_major_q, delta_minor_q;
	logic signed [EW-1:0]         error_term_q;
	logic [COLOR_BITS-1:0]        held_color_q;

	// output register
	logic                         out_valid_q, last_pixel_q;
	logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic [COLOR_BITS-1:0]        pixel_color_q;

	// start set-up
	logic                         swap_ends;
	logic signed [COORD_BITS-1:0] lo_maj, lo_min, hi_maj, hi_min;
	logic [COORD_BITS:0]          dmaj_full;
	logic signed [COORD_BITS:0]   dmin_full;
	logic [COORD_BITS:0]          dmin_abs;

	// step
	logic                         is_start, emit, last_now, out_free;
	logic signed [EW-1:0]         e_sub, e_next;
	logic                         e_neg;

	assign {hd_req, hd_steep, hd_a_maj, hd_a_min, hd_b_maj, hd_b_min, hd_color} = head_data;

	always_comb begin
		swap_ends = hd_a_maj > hd_b_maj;
		lo_maj    = swap_ends ? hd_b_maj : hd_a_maj;
		lo_min    = swap_ends ? hd_b_min : hd_a_min;
		hi_maj    = swap_ends ? hd_a_maj : hd_b_maj;
		hi_min    = swap_ends ? hd_a_min : hd_b_min;
		dmaj_full = {hi_maj[COORD_BITS-1], hi_maj} - {lo_maj[COORD_BITS-1], lo_maj};
		dmin_full = {hi_min[COORD_BITS-1], hi_min} - {lo_min[COORD_BITS-1], lo_min};
		dmin_abs  = dmin_full[COORD_BITS] ? (COORD_BITS+1)'(-dmin_full) : dmin_full;
	end

	always_comb begin
		e_sub  = error_term_q - $signed({2'b00, delta_minor_q});
		e_neg  = e_sub[EW-1];
		e_next = e_neg ? e_sub + $signed({2'b00, delta_major_q}) : e_sub;
	end

	assign out_free = !out_valid_q || out_ready;
	assign is_start = (hd_req == REQ_START);
	assign pop      = head_valid && (is_start || !line_active_q || out_free);
	assign emit     = pop && !is_start && line_active_q;
	assign last_now = !(major_pos_q < major_end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop && is_start) begin
				line_active_q <= 1'b1;
			end else if (emit && last_now) begin
				line_active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_start) begin
			axes_swapped_q <= hd_steep;
			major_pos_q    <= lo_maj;
			minor_pos_q    <= lo_min;
			major_end_q    <= hi_maj;
			delta_major_q  <= dmaj_full[COORD_BITS-1:0];
			delta_minor_q  <= dmin_abs[COORD_BITS-1:0];
			error_term_q   <= $signed({3'b000, dmaj_full[COORD_BITS-1:1]});
			minor_down_q   <= !(lo_min < hi_min);
			held_color_q   <= hd_color;
		end else if (emit && !last_now) begin
			major_pos_q  <= major_pos_q + 1'b1;
			error_term_q <= e_next;
			if (e_neg) begin
				minor_pos_q <= minor_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
			end
		end
		if (emit) begin
			pixel_x_q     <= axes_swapped_q ? minor_pos_q : major_pos_q;
			pixel_y_q     <= axes_swapped_q ? major_pos_q : minor_pos_q;
			pixel_color_q <= held_color_q;
			last_pixel_q  <= last_now;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last_pixel  = last_pixel_q;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_now) |=> !line_active_q)
		else $error("line still active after last pixel");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_active_q |-> (major_pos_q <= major_end_q))
		else $error("major position ran past line end");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(pixel_x_q)
			&& $stable(pixel_y_q) && $stable(pixel_color_q) && $stable(last_pixel_q)))
		else $error("pixel changed while stalled");

endmodule

/* hdl/bresenham_line_rasterizer.sv */
// Bresenham line rasterizer top level: front end, command queue and stepper.
// Requests pass the queue, then the stepper. Throughput: one request per cycle if the
// queue is not full; the stepper retires one queue entry per clock, set by its single
// add-and-compare error update and one-entry pixel register; advances wait on a stall.
// Reset (arst_n low, asynchronous): queue empties, no line active, no pixel pending.
// A start transaction produces no pixel; an advance while idle is dropped.
module bresenham_line_rasterizer
	import brl_pkg::*;
#(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0]        color_value,
	// pixel channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0]        pixel_color,
	output logic                         last_pixel
);

	// queue entry: request code, steep flag, endpoints in major/minor order, colour
	localparam int ENTRY_W = 2 + 4 * COORD_BITS + COLOR_BITS;

	logic               push, pop, queue_full, head_valid;
	logic [ENTRY_W-1:0] push_data, head_data;

	// Front end: steepness test and axis swap happen at accept time, so the
	// stepper only has to order endpoints when it loads a line.
	brl_front #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.color_value (color_value),
		.queue_full  (queue_full),
		.push        (push),
		.push_data   (push_data)
	);

	// Short queue decouples request acceptance from pixel back-pressure.
	brl_fifo #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Stepper: start entries load state, advance entries emit one pixel each while a line is active.
	// Start and idle-advance entries retire even while the pixel register stalls.
	brl_back #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (ENTRY_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule
